// ===== rtl/i2cdws_pkg.sv =====
// shared types and constants of the i2c dac write frame serializer
// no dependencies; used by every module of the block and by its checker
package i2cdws_pkg;

    localparam logic [7:0]  ADDR_RESET    = 8'hAE;
    localparam logic [15:0] DATA_LIMIT    = 16'd4095;
    localparam int unsigned JUSTIFY_SHIFT = 4;

    // bus symbol codes on symbol_kind
    localparam logic [1:0] SYM_START = 2'd0;
    localparam logic [1:0] SYM_BIT   = 2'd1;
    localparam logic [1:0] SYM_ACK   = 2'd2;
    localparam logic [1:0] SYM_STOP  = 2'd3;

    localparam int unsigned BYTES_PER_FRAME = 4;

    // the four bytes of one write transaction, first sent in the top byte
    typedef struct packed {
        logic [7:0] addr;
        logic [7:0] cmd_ch;
        logic [7:0] data_hi;
        logic [7:0] data_lo;
    } frame_t;

    // queue read side as seen by the serializer
    typedef struct packed {
        logic   valid;
        frame_t frame;
    } frame_q_t;

endpackage

// ===== rtl/i2c_dac_write_frame_serializer.sv =====
// top level of the i2c dac write frame serializer: front end, frame queue
// and symbol serializer; depends on i2cdws_pkg, i2cdws_front/queue/back
//
// usage
//   requests enter through push/full: dac_command, channel, data_word and
//   left_justify are taken at an edge with push high and full low. a
//   request whose data_word exceeds 4095 is taken and dropped, it makes
//   no symbols. cfg_we/cfg_wdata write the slave address byte (reset 0xAE);
//   use them only while the block is idle; the block does not enforce it.
//   symbols leave through empty/pop: symbol_kind, sda_level and last_symbol
//   show the oldest symbol while empty is low; pop takes it.
// timing
//   each request in range makes 38 symbols (start, four bytes of eight bits
//   plus an ack slot, stop). the serializer emits one symbol per cycle
//   while pop is high, with no gap between requests. with the serializer
//   idle a taken request is written to the queue and then loaded into the
//   output register, where its start symbol shows.
//   QUEUE_DEPTH frames wait between front end and serializer; full rises
//   once they are all taken.
// reset and stall
//   reset empties the queue and the output stage and restores the address.
//   while pop is low the shown symbol holds and the serializer waits; once
//   the queue fills, full holds off further requests.
module i2c_dac_write_frame_serializer #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  dac_command,
    input  logic [7:0]  channel,
    input  logic [15:0] data_word,
    input  logic        left_justify,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  symbol_kind,
    output logic        sda_level,
    output logic        last_symbol
);

    logic                 q_wr;
    logic                 q_rd;
    i2cdws_pkg::frame_t   q_wdata;
    i2cdws_pkg::frame_q_t rq;

    i2cdws_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .push         (push),
        .q_full       (full),
        .dac_command  (dac_command),
        .channel      (channel),
        .data_word    (data_word),
        .left_justify (left_justify),
        .q_wr         (q_wr),
        .q_wdata      (q_wdata)
    );

    i2cdws_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (q_wr),
        .wdata (q_wdata),
        .full  (full),
        .rd    (q_rd),
        .rq    (rq)
    );

    i2cdws_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .rq          (rq),
        .q_rd        (q_rd),
        .empty       (empty),
        .pop         (pop),
        .symbol_kind (symbol_kind),
        .sda_level   (sda_level),
        .last_symbol (last_symbol)
    );

endmodule

// ===== rtl/i2cdws_front.sv =====
// front end: holds the slave address register, checks each request and
// builds its four-byte frame; depends on i2cdws_pkg
module i2cdws_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [7:0]          cfg_wdata,
    input  logic                push,
    input  logic                q_full,
    input  logic [7:0]          dac_command,
    input  logic [7:0]          channel,
    input  logic [15:0]         data_word,
    input  logic                left_justify,
    output logic                q_wr,
    output i2cdws_pkg::frame_t  q_wdata
);

    logic [7:0]  slave_address_byte_reg;
    logic [7:0]  slave_address_byte_next;
    logic [15:0] code;
    logic        code_ok;

    always_comb
    begin
        slave_address_byte_next = slave_address_byte_reg;
        if (cfg_we)
        begin
            slave_address_byte_next = cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slave_address_byte_reg <= i2cdws_pkg::ADDR_RESET;
        end
        else
        begin
            slave_address_byte_reg <= slave_address_byte_next;
        end
    end

    // an out of range code drops the item here, it never reaches the queue
    assign code_ok = (data_word <= i2cdws_pkg::DATA_LIMIT);
    assign code    = left_justify ? (data_word << i2cdws_pkg::JUSTIFY_SHIFT) : data_word;
    assign q_wr    = push && !q_full && code_ok;

    always_comb
    begin
        q_wdata.addr    = slave_address_byte_reg;
        q_wdata.cmd_ch  = dac_command | channel;
        q_wdata.data_hi = code[15:8];
        q_wdata.data_lo = code[7:0];
    end

endmodule

// ===== rtl/i2cdws_queue.sv =====
// short frame queue between the front end and the serializer
// depends on i2cdws_pkg for the frame type
module i2cdws_queue #(
    parameter int DEPTH = 2
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr,
    input  i2cdws_pkg::frame_t   wdata,
    output logic                 full,
    input  logic                 rd,
    output i2cdws_pkg::frame_q_t rq
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);
    localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);

    i2cdws_pkg::frame_t mem [DEPTH];

    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_wr, do_rd;

    assign full  = (count_reg == DEPTH_CNT);
    assign do_wr = wr && !full;
    assign do_rd = rd && (count_reg != '0);

    assign rq.valid = (count_reg != '0);
    assign rq.frame = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_IDX) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_IDX) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ===== rtl/i2cdws_back.sv =====
// back end: turns one queued frame into 38 bus symbols, one per cycle while pop is high,
// through a registered output stage; depends on i2cdws_pkg
module i2cdws_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  i2cdws_pkg::frame_q_t rq,
    output logic                 q_rd,
    output logic                 empty,
    input  logic                 pop,
    output logic [1:0]           symbol_kind,
    output logic                 sda_level,
    output logic                 last_symbol
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_BITS = 4'b0010,
        ST_ACK  = 4'b0100,
        ST_STOP = 4'b1000
    } state_t;

    localparam logic [1:0] LAST_BYTE = 2'(i2cdws_pkg::BYTES_PER_FRAME - 1);

    state_t      state_reg, state_next;
    logic [31:0] shift_reg, shift_next;
    logic [2:0]  bit_cnt_reg, bit_cnt_next;
    logic [1:0]  byte_cnt_reg, byte_cnt_next;
    logic        out_valid_reg, out_valid_next;
    logic [1:0]  kind_reg, kind_next;
    logic        sda_reg, sda_next;
    logic        last_reg, last_next;
    logic        adv;

    // output slot is free or is being taken this cycle
    assign adv = !out_valid_reg || pop;
    assign q_rd = adv && (state_reg == ST_IDLE) && rq.valid;

    always_comb
    begin
        state_next     = state_reg;
        shift_next     = shift_reg;
        bit_cnt_next   = bit_cnt_reg;
        byte_cnt_next  = byte_cnt_reg;
        out_valid_next = out_valid_reg;
        kind_next      = kind_reg;
        sda_next       = sda_reg;
        last_next      = last_reg;
        if (adv)
        begin
            out_valid_next = 1'b1;
            last_next      = 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    // start goes out in the same cycle the frame is loaded
                    kind_next      = i2cdws_pkg::SYM_START;
                    sda_next       = 1'b0;
                    out_valid_next = rq.valid;
                    if (rq.valid)
                    begin
                        shift_next    = rq.frame;
                        bit_cnt_next  = '0;
                        byte_cnt_next = '0;
                        state_next    = ST_BITS;
                    end
                end
                ST_BITS:
                begin
                    kind_next    = i2cdws_pkg::SYM_BIT;
                    sda_next     = shift_reg[31];
                    shift_next   = {shift_reg[30:0], 1'b0};
                    bit_cnt_next = bit_cnt_reg + 1'b1;
                    if (bit_cnt_reg == 3'd7)
                    begin
                        state_next = ST_ACK;
                    end
                end
                ST_ACK:
                begin
                    kind_next = i2cdws_pkg::SYM_ACK;
                    sda_next  = 1'b1;
                    if (byte_cnt_reg == LAST_BYTE)
                    begin
                        state_next = ST_STOP;
                    end
                    else
                    begin
                        byte_cnt_next = byte_cnt_reg + 1'b1;
                        state_next    = ST_BITS;
                    end
                end
                ST_STOP:
                begin
                    kind_next  = i2cdws_pkg::SYM_STOP;
                    sda_next   = 1'b1;
                    last_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                default:
                begin
                    out_valid_next = 1'b0;
                    state_next     = ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            bit_cnt_reg   <= '0;
            byte_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bit_cnt_reg   <= bit_cnt_next;
            byte_cnt_reg  <= byte_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        kind_reg  <= kind_next;
        sda_reg   <= sda_next;
        last_reg  <= last_next;
    end

    assign empty       = !out_valid_reg;
    assign symbol_kind = kind_reg;
    assign sda_level   = sda_reg;
    assign last_symbol = last_reg;

endmodule

// ===== rtl/i2cdws_checker.sv =====
// port level checks of the i2c dac write frame serializer, bound to the
// top level; depends on i2cdws_pkg
module i2cdws_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       empty,
    input logic       pop,
    input logic [1:0] symbol_kind,
    input logic       sda_level,
    input logic       last_symbol
);

    // nothing is offered after an edge seen in reset
    a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
        else $error("symbol offered during reset");

    // last_symbol marks exactly the stop
    a_last_is_stop: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (last_symbol == (symbol_kind == i2cdws_pkg::SYM_STOP)))
        else $error("last_symbol does not match stop");

    // start drives sda low, ack slot and stop release it
    a_sda_fixed: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> ((symbol_kind == i2cdws_pkg::SYM_START && !sda_level)
                 || (symbol_kind == i2cdws_pkg::SYM_BIT)
                 || (symbol_kind != i2cdws_pkg::SYM_START && sda_level)))
        else $error("wrong sda level for start, ack or stop");

    // a taken stop is followed only by a new start
    a_start_after_stop: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && last_symbol)
        |=> (empty || symbol_kind == i2cdws_pkg::SYM_START))
        else $error("symbol after stop is not a start");

    // a waiting symbol holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(symbol_kind)
                              && $stable(sda_level) && $stable(last_symbol)))
        else $error("waiting symbol changed");

endmodule

bind i2c_dac_write_frame_serializer i2cdws_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .empty       (empty),
    .pop         (pop),
    .symbol_kind (symbol_kind),
    .sda_level   (sda_level),
    .last_symbol (last_symbol)
);

// ===== bench/tb.sv =====
// testbench of i2c_dac_write_frame_serializer: random and directed dac write
// requests, random stalls on both queue sides, symbol-by-symbol scoreboard
// depends on rtl/i2cdws_pkg.sv and rtl/i2c_dac_write_frame_serializer.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import i2cdws_pkg::*;

    localparam int HOLD_CYCLES  = 400;
    localparam int SETTLE       = 8;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 45;

    typedef struct packed {
        logic [1:0] kind;
        logic       sda;
        logic       last;
    } symbol_t;

    class symbol_scoreboard;
        symbol_t    expected_symbols[$];
        logic [7:0] slave_addr;
        int         errors;

        function new();
            slave_addr = ADDR_RESET;
            errors     = 0;
        endfunction

        function void set_address(logic [7:0] addr);
            slave_addr = addr;
        endfunction

        function int pending();
            return expected_symbols.size();
        endfunction

        function void add_symbol(logic [1:0] kind, logic sda, logic last);
            symbol_t s;
            s.kind = kind;
            s.sda  = sda;
            s.last = last;
            expected_symbols.push_back(s);
        endfunction

        // builds the 38 bus symbols of one write transaction
        function void frame_accepted(logic [7:0] cmd, logic [7:0] ch,
                                     logic [15:0] code, logic just);
            logic [15:0] value;
            logic [31:0] frame_bytes;
            if (code > DATA_LIMIT)
                return;
            value = just ? (code << JUSTIFY_SHIFT) : code;
            frame_bytes = {slave_addr, cmd | ch, value};
            add_symbol(SYM_START, 1'b0, 1'b0);
            for (int b = 0; b < BYTES_PER_FRAME; b++)
            begin
                for (int i = 0; i < 8; i++)
                    add_symbol(SYM_BIT, frame_bytes[31 - 8 * b - i], 1'b0);
                add_symbol(SYM_ACK, 1'b1, 1'b0);
            end
            add_symbol(SYM_STOP, 1'b1, 1'b1);
        endfunction

        task report(string msg);
            $display("ERROR at %0t ns: %s", $time, msg);
            errors++;
        endtask

        task check_symbol(symbol_t got);
            symbol_t want;
            if (expected_symbols.size() == 0)
            begin
                report($sformatf("unexpected symbol kind %0d sda %0d last %0d",
                                 got.kind, got.sda, got.last));
                return;
            end
            want = expected_symbols.pop_front();
            if (got.kind !== want.kind)
                report($sformatf("symbol_kind %0d, expected %0d", got.kind, want.kind));
            if (got.sda !== want.sda)
                report($sformatf("sda_level %0d, expected %0d", got.sda, want.sda));
            if (got.last !== want.last)
                report($sformatf("last_symbol %0d, expected %0d", got.last, want.last));
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [7:0]  cfg_wdata = 8'h00;
    logic        push = 1'b0;
    logic        full;
    logic [7:0]  dac_command = 8'h00;
    logic [7:0]  channel = 8'h00;
    logic [15:0] data_word = 16'h0000;
    logic        left_justify = 1'b0;
    logic        empty;
    logic        pop = 1'b0;
    logic [1:0]  symbol_kind;
    logic        sda_level;
    logic        last_symbol;

    symbol_scoreboard board = new();
    bit send_burst = 1'b0;
    bit hold_req = 1'b0;

    i2c_dac_write_frame_serializer u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .push         (push),
        .full         (full),
        .dac_command  (dac_command),
        .channel      (channel),
        .data_word    (data_word),
        .left_justify (left_justify),
        .empty        (empty),
        .pop          (pop),
        .symbol_kind  (symbol_kind),
        .sda_level    (sda_level),
        .last_symbol  (last_symbol)
    );

    always #10 clk = ~clk;

    // push stays high from one item to the next when no gap is drawn
    task automatic send_request(logic [7:0] cmd, logic [7:0] ch,
                                logic [15:0] code, logic just);
        int gap;
        if ($urandom_range(0, 39) == 0)
            send_burst = !send_burst;
        gap = send_burst ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push         <= 1'b1;
        dac_command  <= cmd;
        channel      <= ch;
        data_word    <= code;
        left_justify <= just;
        do @(posedge clk); while (full);
        board.frame_accepted(cmd, ch, code, just);
    endtask

    task automatic send_random();
        logic [7:0]  cmd;
        logic [7:0]  ch;
        logic [15:0] code;
        int          pick;
        cmd  = 8'($urandom_range(0, 255));
        ch   = 8'($urandom_range(0, 255));
        pick = $urandom_range(0, 99);
        if (pick < 10)
            ch = 8'h00;
        else if (pick < 20)
            cmd = 8'h00;
        pick = $urandom_range(0, 99);
        if (pick < 80)
            code = 16'($urandom_range(0, 4095));
        else if (pick < 86)
            code = ($urandom_range(0, 1) != 0) ? 16'd4095 : 16'd0;
        else
            code = 16'($urandom_range(4096, 65535));   // rejected request
        send_request(cmd, ch, code, 1'($urandom_range(0, 1)));
    endtask

    task automatic write_address(logic [7:0] addr);
        cfg_we    <= 1'b1;
        cfg_wdata <= addr;
        @(posedge clk);
        cfg_we <= 1'b0;
        board.set_address(addr);
    endtask

    // drain all symbols, then wait with push low before going on
    task automatic drain();
        push <= 1'b0;
        while (board.pending() > 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    initial
    begin : stimulus
        logic [7:0] addr;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed items at the reset address
        send_request(8'h00, 8'h00, 16'd0, 1'b0);
        send_request(8'hFF, 8'hFF, 16'd4095, 1'b0);
        send_request(8'hFF, 8'h00, 16'd4095, 1'b1);
        send_request(8'h00, 8'hFF, 16'h0800, 1'b1);
        send_request(8'hA0, 8'h05, 16'h0ABC, 1'b0);
        send_request(8'h30, 8'h0F, 16'h0ABC, 1'b1);
        send_request(8'h12, 8'h34, 16'd4096, 1'b0);
        send_request(8'h56, 8'h78, 16'hFFFF, 1'b1);
        send_request(8'h9A, 8'hBC, 16'h8000, 1'b0);
        send_request(8'h55, 8'hAA, 16'h0555, 1'b0);
        send_request(8'hAA, 8'h55, 16'h0AAA, 1'b1);
        send_request(8'h80, 8'h01, 16'd1, 1'b0);
        send_request(8'h01, 8'h80, 16'h0800, 1'b0);
        send_request(8'h0F, 8'hF0, 16'd4097, 1'b1);
        send_request(8'hC3, 8'h3C, 16'd4095, 1'b1);
        send_request(8'h00, 8'h00, 16'd0, 1'b1);
        send_request(8'h7E, 8'h81, 16'h0F0F, 1'b0);
        send_request(8'h24, 8'h42, 16'h00F0, 1'b1);
        drain();

        for (int p = 0; p < PHASES; p++)
        begin
            if (p == 0)
                addr = 8'h00;
            else if (p == 1)
                addr = 8'hFF;
            else
                addr = 8'($urandom_range(0, 255));
            write_address(addr);
            if (p == 3)
                hold_req = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_random();
            drain();
        end

        repeat (SETTLE * 5) @(posedge clk);
        if (board.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin : symbol_sink
        int      gap;
        bit      burst;
        symbol_t got;
        burst = 1'b0;
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 39) == 0)
                burst = !burst;
            gap = burst ? 0 : $urandom_range(0, 15);
            // long hold-off so the frame queue fills and full rises
            if (hold_req)
            begin
                gap = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (gap > 0)
            begin
                pop <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            pop <= 1'b1;
            do @(posedge clk); while (empty);
            got.kind = symbol_kind;
            got.sda  = sda_level;
            got.last = last_symbol;
            board.check_symbol(got);
        end
    end

    initial
    begin : watchdog
        #30_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
